@@ rtl/sfr_pkg.sv @@
package sfr_pkg;

  // Frame layout of the serial radio-control protocol.
  localparam int FRAME_LEN        = 25;
  localparam int LATCH_LEN        = 14;
  localparam int LATCH_BITS       = LATCH_LEN * 8;
  localparam int CH_BITS          = 11;
  localparam int NUM_CHANNELS_DEF = 10;
  localparam int CNT_W            = 5;

  localparam logic [7:0]  HDR_BYTE  = 8'h0f;
  localparam logic [7:0]  FTR_BYTE  = 8'h00;
  localparam logic [15:0] BAD_VALUE = 16'hffff;
  localparam logic [7:0]  GAP_RESET = 8'd3;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_READ = 1'b1
  } req_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic [3:0]  channel;
  } in_item_t;

endpackage

@@ rtl/sfr_if.sv @@
interface sfr_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  rx_byte;
  logic [31:0] now_ms;
  logic [3:0]  channel;

  modport source (output valid, req_type, rx_byte, now_ms, channel, input ready);
  modport sink   (input valid, req_type, rx_byte, now_ms, channel, output ready);
endinterface

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] channel_value;
  logic [3:0]  valid_count;
  logic        frame_accepted;

  modport source (output valid, channel_value, valid_count, frame_accepted, input ready);
  modport sink   (input valid, channel_value, valid_count, frame_accepted, output ready);
endinterface

interface sfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] gap_ms;

  modport source (output valid, gap_ms, input ready);
  modport sink   (input valid, gap_ms, output ready);
endinterface

@@ rtl/sbus_frame_receiver_top.sv @@
// An accepted input transaction moves through the input register, then the result
// register. Throughput: one transaction per cycle while out_ch.ready does not stall
// the result register; the only loop is the state update.
// Reset (rst_n, synchronous, active low) clears byte count, time, valid mask and the
// pipeline valid flags, and loads gap_ms with 3. Frame and latch contents stay undefined.
module sbus_frame_receiver_top
  import sfr_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sfr_in_if.sink    in_ch,
  sfr_out_if.source out_ch,
  sfr_cfg_if.sink   cfg_ch
);

  localparam logic [NUM_CHANNELS-1:0] ALL_MASK = '1;

  // Input register stage. An item waits here until the result register can take
  // its result; all state is read and updated when it moves on.
  logic     s1_vld_r;
  in_item_t s1_r;
  logic     adv;

  // Result register.
  logic        out_vld_r;
  logic [15:0] out_value_r;
  logic [3:0]  out_count_r;
  logic        out_acc_r;

  // Block state. Only the frame bytes that are ever examined are kept: the header,
  // bytes 1..14 (which carry all channels) and the footer at position 24.
  logic [7:0]              gap_r;
  logic                    seen_r;
  logic [31:0]             last_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;
  logic [7:0]              hdr_r;
  logic [7:0]              ftr_r;
  logic [7:0]              mid_r [LATCH_LEN];
  logic [LATCH_BITS-1:0]   latch_r;
  logic [LATCH_BITS-1:0]   latch_nxt;
  logic [NUM_CHANNELS-1:0] vmask_r;
  logic [NUM_CHANNELS-1:0] vmask_nxt;

  logic                    is_byte;
  logic [31:0]             gap_c;
  logic                    close_c;
  logic                    good_c;
  logic                    accept_c;
  logic [CNT_W-1:0]        cnt_eff;
  logic                    wr_c;
  logic [NUM_CHANNELS-1:0] hit;
  logic [15:0]             value_c;
  logic [3:0]              count_c;

  // The input side takes a transaction whenever the input register is empty or its
  // item can advance, so it is taken while a result waits downstream only if empty.
  assign adv         = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_r.req_type <= in_ch.req_type;
      s1_r.rx_byte  <= in_ch.rx_byte;
      s1_r.now_ms   <= in_ch.now_ms;
      s1_r.channel  <= in_ch.channel;
    end
  end

  // Frame timing: the first byte only records its arrival time. Any later byte
  // whose distance to the previous one reaches gap_ms closes the current frame,
  // which is latched when it has the right length, header and footer.
  always_comb begin
    is_byte  = (s1_r.req_type == REQ_BYTE);
    gap_c    = s1_r.now_ms - last_r;
    close_c  = seen_r && (gap_c >= 32'(gap_r));
    good_c   = (cnt_r == CNT_W'(FRAME_LEN)) && (hdr_r == HDR_BYTE) && (ftr_r == FTR_BYTE);
    accept_c = is_byte && close_c && good_c;
    cnt_eff  = close_c ? '0 : cnt_r;
    wr_c     = adv && is_byte;
    // The count stops one past the frame length, so an overlong frame never passes.
    cnt_nxt  = (cnt_eff < CNT_W'(FRAME_LEN + 1)) ? cnt_eff + 1'b1 : cnt_eff;
  end

  // Channel k is the 11-bit little-endian field at frame bit 8 + 11k, which is
  // bit 11k of the latched bytes 1..14 taken as one vector.
  always_comb begin
    for (int i = 0; i < LATCH_LEN; i++) begin
      latch_nxt[i*8 +: 8] = mid_r[i];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      hit[k] = (s1_r.channel == 4'(k));
    end
    if (is_byte) begin
      value_c = '0;
    end else begin
      value_c = BAD_VALUE;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        if (hit[k] && vmask_r[k]) begin
          value_c = 16'(latch_r[k*CH_BITS +: CH_BITS]);
        end
      end
    end
    if (accept_c) begin
      vmask_nxt = ALL_MASK;
    end else if (!is_byte) begin
      vmask_nxt = vmask_r & ~hit;
    end else begin
      vmask_nxt = vmask_r;
    end
    count_c = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      count_c = count_c + 4'(vmask_nxt[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r   <= GAP_RESET;
      seen_r  <= 1'b0;
      last_r  <= '0;
      cnt_r   <= '0;
      vmask_r <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        gap_r <= cfg_ch.gap_ms;
      end
      if (wr_c) begin
        seen_r <= 1'b1;
        last_r <= s1_r.now_ms;
        cnt_r  <= cnt_nxt;
      end
      if (adv) begin
        vmask_r <= vmask_nxt;
      end
    end
  end

  // Frame byte storage, written at the position the byte lands on.
  always_ff @(posedge clk) begin
    if (wr_c) begin
      if (cnt_eff == '0) begin
        hdr_r <= s1_r.rx_byte;
      end
      if (cnt_eff == CNT_W'(FRAME_LEN - 1)) begin
        ftr_r <= s1_r.rx_byte;
      end
      for (int i = 0; i < LATCH_LEN; i++) begin
        if (cnt_eff == CNT_W'(i + 1)) begin
          mid_r[i] <= s1_r.rx_byte;
        end
      end
    end
    if (adv && accept_c) begin
      latch_r <= latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r <= value_c;
      out_count_r <= count_c;
      out_acc_r   <= accept_c;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.channel_value  = out_value_r;
  assign out_ch.valid_count    = out_count_r;
  assign out_ch.frame_accepted = out_acc_r;

  // A latched frame makes every channel valid.
  a_accept_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && accept_c) |=> (vmask_r == ALL_MASK))
    else $error("accepted frame did not set all channel-valid bits");

  a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_acc_r) |-> (out_count_r == 4'(NUM_CHANNELS)))
    else $error("accepted frame reported a partial valid count");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FRAME_LEN + 1))
    else $error("byte count passed its saturation point");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_value_r != BAD_VALUE)) |-> (out_value_r[15:CH_BITS] == '0))
    else $error("channel value wider than a channel field");

  a_read_keeps_time: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !is_byte) |=> ($stable(last_r) && $stable(cnt_r)))
    else $error("read request changed frame timing state");

endmodule
